>>> design/page_cache_lsn_aware_eviction_core_assert.svh
// Assertion macros shared by the page cache eviction design.
`ifndef PAGE_CACHE_LSN_AWARE_EVICTION_CORE_ASSERT_SVH
`define PAGE_CACHE_LSN_AWARE_EVICTION_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PCE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pce: invariant violated");

// Antecedent implies consequent in the next cycle.
`define PCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pce: sequence violated");

`endif

>>> design/pce_pkg.sv
// Shared types, codes and sizes for the page cache eviction design.
package pce_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;

    localparam logic [1:0] REQ_PUT     = 2'd0;
    localparam logic [1:0] REQ_EVICT   = 2'd1;
    localparam logic [1:0] REQ_EXTRACT = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] page_id;
        logic        dirty_in;
        logic [63:0] page_seq_in;
        logic [3:0]  frame_tag_in;
        logic [63:0] flushed_seq;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      page_id_out;
        logic             dirty_out;
        logic [63:0]      page_seq_out;
        logic [3:0]       frame_tag_out;
        logic [OCC_W-1:0] occupancy;
        logic [31:0]      hit_total;
        logic [31:0]      miss_total;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [31:0] page;
        logic        dirty;
        logic [63:0] seq;
        logic [3:0]  tag;
    } t_entry;

    // Per-transaction control broadcast to every cell.
    typedef struct packed {
        logic evict_mode;  // hit on evictable rather than on page id match
        logic remove;      // close up the table behind the first hit
        logic append;      // load the new entry into the first free cell
    } t_cell_ctl;

endpackage

>>> design/pce_cell.sv
// One table entry: holds a frame, compares it, and shifts toward the head on removal.
module pce_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pce_pkg::t_cell_ctl i_ctl,
    input  pce_pkg::t_req      i_req,
    input  logic               i_prev_valid,
    input  logic               i_found_prev,
    input  pce_pkg::t_entry    i_right,
    output pce_pkg::t_entry    o_entry,
    output logic               o_found,
    output pce_pkg::t_entry    o_pick
);
    import pce_pkg::*;

    logic        r_valid;
    logic [31:0] r_page;
    logic        r_dirty;
    logic [63:0] r_seq;
    logic [3:0]  r_tag;

    logic        n_valid;
    logic [31:0] n_page;
    logic        n_dirty;
    logic [63:0] n_seq;
    logic [3:0]  n_tag;

    logic w_evictable;
    logic w_match;
    logic w_hit;
    logic w_sel;
    logic w_shift;
    logic w_load;

    assign w_evictable = r_valid && (!r_dirty || (r_seq <= i_req.flushed_seq));
    assign w_match     = r_valid && (r_page == i_req.page_id);
    assign w_hit       = i_ctl.evict_mode ? w_evictable : w_match;
    assign o_found     = i_found_prev | w_hit;
    assign w_sel       = i_ctl.remove && w_hit && !i_found_prev;
    // every cell at or behind the removed one takes its right neighbor
    assign w_shift     = i_ctl.remove && o_found;
    assign w_load      = i_ctl.append && !r_valid && i_prev_valid;

    assign o_entry = '{valid: r_valid, page: r_page, dirty: r_dirty, seq: r_seq, tag: r_tag};
    assign o_pick  = w_sel ? o_entry : '0;

    // remove and append never come together, so shift and load exclude each other
    always_comb begin
        n_valid = r_valid;
        n_page  = r_page;
        n_dirty = r_dirty;
        n_seq   = r_seq;
        n_tag   = r_tag;
        if (w_shift) begin
            n_valid = i_right.valid;
            n_page  = i_right.page;
            n_dirty = i_right.dirty;
            n_seq   = i_right.seq;
            n_tag   = i_right.tag;
        end else if (w_load) begin
            n_valid = 1'b1;
            n_page  = i_req.page_id;
            n_dirty = i_req.dirty_in;
            n_seq   = i_req.page_seq_in;
            n_tag   = i_req.frame_tag_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page  <= n_page;
        r_dirty <= n_dirty;
        r_seq   <= n_seq;
        r_tag   <= n_tag;
    end

endmodule

>>> design/page_cache_lsn_aware_eviction_core.sv
// Top level: FIFO page cache with WAL-aware eviction, built as a chain of entry cells.
// Each request (put, evict, extract by page id) is taken when i_start is high and
// o_busy is low, and its result appears on o_rsp with o_done high for exactly one
// cycle on the following cycle; there is no way to stall the result, so capture it
// then. A new request may be issued every cycle. The rate is set by the row of
// entry cells, which all compare in parallel and close up a removed slot in a
// single shift step. o_busy is high during reset and in the cycle right after it.
module page_cache_lsn_aware_eviction_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  pce_pkg::t_req i_req,
    output logic          o_done,
    output pce_pkg::t_rsp o_rsp
);
    import pce_pkg::*;

    `include "page_cache_lsn_aware_eviction_core_assert.svh"

    logic             r_busy;
    logic             r_done;
    t_rsp             r_rsp;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_hits;
    logic [31:0]      r_misses;

    logic [CNT_W-1:0] n_count;
    logic [31:0]      n_hits;
    logic [31:0]      n_misses;
    t_rsp             n_rsp;

    logic                w_accept;
    logic                w_dup;
    logic                w_full;
    logic                w_any;
    t_cell_ctl           w_ctl;
    t_entry              w_ent  [CAPACITY];
    t_entry              w_pick [CAPACITY];
    logic [CAPACITY:0]   w_found;
    logic [CAPACITY-1:0] w_vld;
    t_entry              w_sel;

    assign w_accept = i_start && !r_busy;
    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_rsp    = r_rsp;

    assign w_found[0] = 1'b0;
    assign w_any      = w_found[CAPACITY];
    // in put mode the cells hit on page id, so the chain end flags a duplicate
    assign w_dup      = w_any;
    assign w_full     = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        w_ctl.evict_mode = (i_req.req_type == REQ_EVICT);
        w_ctl.remove     = w_accept && ((i_req.req_type == REQ_EVICT) ||
                                        (i_req.req_type == REQ_EXTRACT));
        w_ctl.append     = w_accept && (i_req.req_type == REQ_PUT) && !w_dup && !w_full;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_right;
        logic   w_prev_valid;

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_ent[g+1];
        end

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_rest
            assign w_prev_valid = w_ent[g-1].valid;
        end

        pce_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_req        (i_req),
            .i_prev_valid (w_prev_valid),
            .i_found_prev (w_found[g]),
            .i_right      (w_right),
            .o_entry      (w_ent[g]),
            .o_found      (w_found[g+1]),
            .o_pick       (w_pick[g])
        );

        assign w_vld[g] = w_ent[g].valid;
    end

    // at most one cell drives a nonzero pick
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel = t_entry'(w_sel | w_pick[i]);
        end
    end

    always_comb begin
        n_count  = r_count;
        n_hits   = r_hits;
        n_misses = r_misses;
        n_rsp    = '0;
        n_rsp.status = ST_NONE;
        unique case (i_req.req_type)
            REQ_PUT: begin
                priority if (w_dup) begin
                    n_rsp.status = ST_DUP;
                end else if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_rsp.status = ST_OK;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            REQ_EVICT: begin
                if (w_any) begin
                    n_rsp.status = ST_OK;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            REQ_EXTRACT: begin
                if (w_any) begin
                    n_rsp.status = ST_OK;
                    n_count      = r_count - CNT_W'(1);
                    n_hits       = r_hits + 32'd1;
                end else begin
                    n_misses     = r_misses + 32'd1;
                end
            end
            default: begin
                n_rsp.status = ST_NONE;
            end
        endcase
        n_rsp.page_id_out   = w_sel.page;
        n_rsp.dirty_out     = w_sel.dirty;
        n_rsp.page_seq_out  = w_sel.seq;
        n_rsp.frame_tag_out = w_sel.tag;
        n_rsp.occupancy     = OCC_W'(n_count);
        n_rsp.hit_total     = n_hits;
        n_rsp.miss_total    = n_misses;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_done   <= 1'b0;
            r_count  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else begin
            r_busy <= 1'b0;
            r_done <= w_accept;
            if (w_accept) begin
                r_count  <= n_count;
                r_hits   <= n_hits;
                r_misses <= n_misses;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    `PCE_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `PCE_ASSERT_ALWAYS(a_valid_prefix, i_clk, i_rst_n,
        ((w_vld & (w_vld + CAPACITY'(1))) == '0) && ($countones(w_vld) == int'(r_count)))
    `PCE_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, w_accept, r_done)
    `PCE_ASSERT_NEXT(a_one_counter, i_clk, i_rst_n,
        w_accept && (i_req.req_type == REQ_EXTRACT),
        (r_hits != $past(r_hits)) != (r_misses != $past(r_misses)))

endmodule

>>> verif/pce_result_checker.sv
// Result checker for the page cache: tracks the frame table and compares every response.
`timescale 1ns / 100ps

module pce_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  pce_pkg::t_req i_req,
    input  logic          i_done,
    input  pce_pkg::t_rsp i_rsp,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked,
    output int            o_full_cnt,
    output int            o_dup_cnt,
    output int            o_evict_cnt
);
    import pce_pkg::*;

    localparam int REPORT_MAX = 50;

    // Shadow of the frame table, oldest frame at index 0.
    t_entry      frames [CAPACITY];
    int          held;
    logic [31:0] hit_cnt;
    logic [31:0] miss_cnt;

    t_rsp        rsp_queue [$];

    function automatic int locate_page(logic [31:0] id);
        for (int i = 0; i < held; i++)
            if (frames[i].page == id) return i;
        return -1;
    endfunction

    // Clean frames always go; dirty ones only once their LSN is durable.
    function automatic int oldest_evictable(logic [63:0] flushed);
        for (int i = 0; i < held; i++)
            if (!frames[i].dirty || frames[i].seq <= flushed) return i;
        return -1;
    endfunction

    function automatic void drop_frame(int slot);
        for (int i = slot; i < held - 1; i++)
            frames[i] = frames[i + 1];
        held--;
    endfunction

    function automatic t_rsp cache_step(t_req rq);
        t_rsp r;
        int   slot;
        r        = '0;
        r.status = ST_NONE;
        case (rq.req_type)
            REQ_PUT: begin
                if (locate_page(rq.page_id) >= 0) begin
                    r.status = ST_DUP;
                end else if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    frames[held].valid = 1'b1;
                    frames[held].page  = rq.page_id;
                    frames[held].dirty = rq.dirty_in;
                    frames[held].seq   = rq.page_seq_in;
                    frames[held].tag   = rq.frame_tag_in;
                    held++;
                    r.status = ST_OK;
                end
            end
            REQ_EVICT, REQ_EXTRACT: begin
                slot = (rq.req_type == REQ_EVICT) ? oldest_evictable(rq.flushed_seq)
                                                   : locate_page(rq.page_id);
                if (slot >= 0) begin
                    r.status        = ST_OK;
                    r.page_id_out   = frames[slot].page;
                    r.dirty_out     = frames[slot].dirty;
                    r.page_seq_out  = frames[slot].seq;
                    r.frame_tag_out = frames[slot].tag;
                    drop_frame(slot);
                    if (rq.req_type == REQ_EXTRACT) hit_cnt++;
                end else if (rq.req_type == REQ_EXTRACT) begin
                    miss_cnt++;
                end
            end
            default: ;
        endcase
        r.occupancy  = held[OCC_W-1:0];
        r.hit_total  = hit_cnt;
        r.miss_total = miss_cnt;
        return r;
    endfunction

    task automatic flag(input string field, input logic [63:0] want, input logic [63:0] got);
        if (o_fail_count < REPORT_MAX)
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, field, want, got);
        o_fail_count++;
    endtask

    initial begin
        held         = 0;
        hit_cnt      = '0;
        miss_cnt     = '0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_cnt   = 0;
        o_dup_cnt    = 0;
        o_evict_cnt  = 0;
    end

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            held     = 0;
            hit_cnt  = '0;
            miss_cnt = '0;
            rsp_queue.delete();
        end else begin
            if (i_start && !i_busy) begin
                want = cache_step(i_req);
                rsp_queue = {rsp_queue, want};
                if (want.status == ST_FULL) o_full_cnt++;
                if (want.status == ST_DUP) o_dup_cnt++;
                if (i_req.req_type == REQ_EVICT && want.status == ST_OK) o_evict_cnt++;
            end
            if (i_done === 1'b1) begin
                if (rsp_queue.size() == 0) begin
                    if (o_fail_count < REPORT_MAX)
                        $display("%0t mismatch: response with no request outstanding", $time);
                    o_fail_count++;
                end else begin
                    want = rsp_queue.pop_front();
                    o_checked++;
                    if (i_rsp.status !== want.status)
                        flag("status", 64'(want.status), 64'(i_rsp.status));
                    if (i_rsp.page_id_out !== want.page_id_out)
                        flag("page_id_out", 64'(want.page_id_out), 64'(i_rsp.page_id_out));
                    if (i_rsp.dirty_out !== want.dirty_out)
                        flag("dirty_out", 64'(want.dirty_out), 64'(i_rsp.dirty_out));
                    if (i_rsp.page_seq_out !== want.page_seq_out)
                        flag("page_seq_out", want.page_seq_out, i_rsp.page_seq_out);
                    if (i_rsp.frame_tag_out !== want.frame_tag_out)
                        flag("frame_tag_out", 64'(want.frame_tag_out),
                             64'(i_rsp.frame_tag_out));
                    if (i_rsp.occupancy !== want.occupancy)
                        flag("occupancy", 64'(want.occupancy), 64'(i_rsp.occupancy));
                    if (i_rsp.hit_total !== want.hit_total)
                        flag("hit_total", 64'(want.hit_total), 64'(i_rsp.hit_total));
                    if (i_rsp.miss_total !== want.miss_total)
                        flag("miss_total", 64'(want.miss_total), 64'(i_rsp.miss_total));
                end
            end
        end
        o_pending <= rsp_queue.size();
    end

endmodule

>>> verif/page_cache_lsn_aware_eviction_core_test.sv
// Testbench top for the page cache: request stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module page_cache_lsn_aware_eviction_core_test;
    import pce_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int NUM_ITEMS   = 1350;
    localparam int QUIET_TAIL  = 200;
    localparam int STALL_LIMIT = 1000;
    localparam int ID_POOL_N   = 24;
    localparam int SEGMENT_LEN = 40;
    localparam logic [63:0] SEQ_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_start;
    logic  o_busy;
    t_req  i_req;
    logic  o_done;
    t_rsp  o_rsp;

    int    fail_n, pending_n, checked_n, full_n, dup_n, evict_n;
    int    stall_cycles;
    int    issued, n_put, n_evict, n_extract, n_unused;
    bit    idle_on;
    logic [31:0] id_pool [ID_POOL_N];

    page_cache_lsn_aware_eviction_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    pce_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_n),
        .o_pending    (pending_n),
        .o_checked    (checked_n),
        .o_full_cnt   (full_n),
        .o_dup_cnt    (dup_n),
        .o_evict_cnt  (evict_n)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Any accepted request or delivered response resets the stall count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles at %0t", STALL_LIMIT, $time);
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_req make_req(logic [1:0] kind, logic [31:0] id, logic dirty,
                                      logic [63:0] seq, logic [3:0] tag,
                                      logic [63:0] flushed);
        t_req rq;
        rq.req_type     = kind;
        rq.page_id      = id;
        rq.dirty_in     = dirty;
        rq.page_seq_in  = seq;
        rq.frame_tag_in = tag;
        rq.flushed_seq  = flushed;
        return rq;
    endfunction

    // Mostly ids from a small pool so puts collide and extracts hit.
    function automatic logic [31:0] pick_page_id();
        if ($urandom_range(0, 49) == 0)
            id_pool[$urandom_range(0, ID_POOL_N - 1)] = $urandom;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return id_pool[$urandom_range(0, ID_POOL_N - 1)];
    endfunction

    // Small values make seq == flushed and near misses common.
    function automatic logic [63:0] pick_seq();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SEQ_MAX;
            2, 3:    return {$urandom, $urandom};
            4:       return SEQ_MAX - 64'($urandom_range(0, 40));
            default: return 64'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic t_req random_req(int put_pct);
        int         pick;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < put_pct)                        kind = REQ_PUT;
        else if (pick < put_pct + (100 - put_pct) / 2) kind = REQ_EVICT;
        else if (pick < 98)                        kind = REQ_EXTRACT;
        else                                       kind = REQ_UNUSED;
        return make_req(kind, pick_page_id(), 1'($urandom), pick_seq(),
                        4'($urandom), pick_seq());
    endfunction

    // Present one transaction from the falling edge and hold it until taken.
    task automatic issue(input t_req rq);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= rq;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        issued++;
        case (rq.req_type)
            REQ_PUT:     n_put++;
            REQ_EVICT:   n_evict++;
            REQ_EXTRACT: n_extract++;
            default:     n_unused++;
        endcase
        @(negedge i_clk);
    endtask

    initial begin
        int put_pct;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_req        = '0;
        stall_cycles = 0;
        issued       = 0;
        n_put        = 0;
        n_evict      = 0;
        n_extract    = 0;
        n_unused     = 0;
        idle_on      = 1'b1;
        put_pct      = 50;
        foreach (id_pool[k]) id_pool[k] = $urandom;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: nothing to evict, extract misses, unused code ignored.
        issue(make_req(REQ_EVICT, 32'h0, 1'b0, '0, 4'h0, SEQ_MAX));
        issue(make_req(REQ_EXTRACT, 32'h0, 1'b0, '0, 4'h0, '0));
        issue(make_req(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, SEQ_MAX, 4'hF, SEQ_MAX));
        // Field extremes, then a duplicate put.
        issue(make_req(REQ_PUT, 32'h0, 1'b0, '0, 4'h0, '0));
        issue(make_req(REQ_PUT, 32'hFFFF_FFFF, 1'b1, SEQ_MAX, 4'hF, SEQ_MAX));
        issue(make_req(REQ_PUT, 32'h0, 1'b1, 64'd5, 4'h3, '0));
        // Fill with dirty frames, then overfill; duplicate wins over full.
        for (int k = 1; k <= CAPACITY - 2; k++)
            issue(make_req(REQ_PUT, 32'(k), 1'b1, 64'(k * 10), 4'(k), '0));
        issue(make_req(REQ_PUT, 32'd100, 1'b0, '0, 4'h1, '0));
        issue(make_req(REQ_PUT, 32'h0, 1'b0, '0, 4'h1, '0));
        // Clean head goes first; then dirty frames by LSN, equality included.
        issue(make_req(REQ_EVICT, '0, 1'b0, '0, 4'h0, '0));
        issue(make_req(REQ_EVICT, '0, 1'b0, '0, 4'h0, 64'd25));
        issue(make_req(REQ_EVICT, '0, 1'b0, '0, 4'h0, 64'd20));
        issue(make_req(REQ_EVICT, '0, 1'b0, '0, 4'h0, 64'd5));
        issue(make_req(REQ_EXTRACT, 32'hFFFF_FFFF, 1'b0, '0, 4'h0, '0));

        // Random traffic in segments that lean toward filling or draining.
        while (issued < NUM_ITEMS) begin
            if (issued % SEGMENT_LEN == 0)
                case ($urandom_range(0, 2))
                    0:       put_pct = 25;
                    1:       put_pct = 50;
                    default: put_pct = 75;
                endcase
            idle_on = (issued < NUM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            issue(random_req(put_pct));
        end
        i_start <= 1'b0;

        while (pending_n != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d requests: %0d put, %0d evict, %0d extract, %0d unused code",
                 issued, n_put, n_evict, n_extract, n_unused);
        $display("%0d responses compared; %0d full, %0d duplicate, %0d successful evictions",
                 checked_n, full_n, dup_n, evict_n);
        if (fail_n == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
